>>> sv/hsn_pkg.sv
// Shared constants, types and state codes of the heightmap surface normal unit.
package hsn_pkg;

    localparam int HEIGHT_BITS = 16;
    localparam int FRAC_BITS   = 14;

    localparam int DIFF_W   = HEIGHT_BITS + 1;
    localparam int VEC_W    = HEIGHT_BITS + 2;
    localparam int MAG_W    = 20;
    localparam int SCALE_SH = 20;
    localparam int NUM_SH   = FRAC_BITS + 10;

    localparam int SUM_W  = 2 * MAG_W + 2;
    localparam int RAD_W  = SUM_W + SCALE_SH;
    localparam int ROOT_W = RAD_W / 2;
    localparam int REM_W  = ROOT_W + 2;

    localparam int QUO_W    = FRAC_BITS + 1;
    localparam int DIVD_W   = MAG_W + NUM_SH + 1;
    localparam int DIV_HI_W = DIVD_W - QUO_W;

    localparam int SQ_CNT_W   = $clog2(MAG_W);
    localparam int ROOT_CNT_W = $clog2(ROOT_W);
    localparam int DIV_CNT_W  = $clog2(QUO_W);

    localparam int XY_W = 16;
    localparam int Z_W  = 15;
    localparam int ONE_Q = 1 << FRAC_BITS;

    localparam int IN_DATA_W  = 5 * XY_W;
    localparam int IN_USER_W  = 9;
    localparam int OUT_DATA_W = 48;
    localparam int OUT_USER_W = 2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_NORM,
        ST_SQR,
        ST_ROOT,
        ST_DIV,
        ST_OUT
    } t_state;

    typedef enum logic [1:0] {
        MODE_HOLD,
        MODE_CALC,
        MODE_UNDEF
    } t_mode;

    typedef struct packed {
        logic            undef;
        logic            held;
        logic [Z_W-1:0]  z;
        logic [XY_W-1:0] y;
        logic [XY_W-1:0] x;
    } t_normal;

endpackage

>>> sv/heightmap_surface_normal_unit.sv
// Heightmap surface normal unit: neighbor decode, serial normalize, square, root, divide.
// Held and undefined items pass through r_res into the output register r_out.
// Computed normals go through up to 19 normalizing shifts, a 20-step squarer,
// a 31-step square root and 15-step dividers, run one after the other.
// One item at a time; a full output register holds the input.
// Synchronous active-low reset clears control and sets the stored normal to zero, undefined.
module heightmap_surface_normal_unit import hsn_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    // center_height, right_height, down_height, left_height, up_height
    input  logic [IN_DATA_W-1:0]  i_s_axis_tdata,
    // center_valid, neighbor_valid[3:0], edge_flags[3:0]
    input  logic [IN_USER_W-1:0]  i_s_axis_tuser,
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    // normal_x, normal_y, normal_z[14:0], zero pad
    output logic [OUT_DATA_W-1:0] o_m_axis_tdata,
    // held_previous, undefined_normal
    output logic [OUT_USER_W-1:0] o_m_axis_tuser
);

    logic signed [HEIGHT_BITS-1:0] w_c, w_r, w_d, w_l, w_u;
    logic signed [DIFF_W-1:0]      w_dr, w_dd, w_dl, w_du;
    logic signed [VEC_W-1:0]       w_er, w_ed, w_el, w_eu;
    logic signed [VEC_W-1:0]       w_vx, w_vy;
    logic                          w_vz_two;
    logic                          w_vr, w_vd, w_vl, w_vu;
    logic                          w_top, w_bot, w_lef, w_rig, w_tl, w_br, w_ok;
    t_mode                         w_mode;
    logic                          w_neg_x, w_neg_y;
    logic [VEC_W-1:0]              w_abs_x, w_abs_y;

    t_state           r_state, n_state;
    logic [MAG_W-1:0] r_mag_x, r_mag_y, r_mag_z, n_mag_x, n_mag_y, n_mag_z;
    logic             r_neg_x, r_neg_y, n_neg_x, n_neg_y;
    t_normal          r_res, n_res;
    t_normal          r_out, n_out;
    logic             r_out_valid, n_out_valid;
    logic [XY_W-1:0]  r_last_x, r_last_y, n_last_x, n_last_y;
    logic [Z_W-1:0]   r_last_z, n_last_z;
    logic             r_last_undef, n_last_undef;

    logic              w_sq_start, w_sq_done;
    logic [SUM_W-1:0]  w_sum;
    logic              w_root_start, w_root_done;
    logic [ROOT_W-1:0] w_root;
    logic              w_div_start, w_div_done, w_div_done_y, w_div_done_z;
    logic [QUO_W-1:0]  w_qx, w_qy, w_qz;
    logic [XY_W-1:0]   w_ext_x, w_ext_y;

    assign w_c = i_s_axis_tdata[0*XY_W +: HEIGHT_BITS];
    assign w_r = i_s_axis_tdata[1*XY_W +: HEIGHT_BITS];
    assign w_d = i_s_axis_tdata[2*XY_W +: HEIGHT_BITS];
    assign w_l = i_s_axis_tdata[3*XY_W +: HEIGHT_BITS];
    assign w_u = i_s_axis_tdata[4*XY_W +: HEIGHT_BITS];

    assign w_dr = DIFF_W'(w_c) - DIFF_W'(w_r);
    assign w_dd = DIFF_W'(w_c) - DIFF_W'(w_d);
    assign w_dl = DIFF_W'(w_c) - DIFF_W'(w_l);
    assign w_du = DIFF_W'(w_c) - DIFF_W'(w_u);
    assign w_er = VEC_W'(w_dr);
    assign w_ed = VEC_W'(w_dd);
    assign w_el = VEC_W'(w_dl);
    assign w_eu = VEC_W'(w_du);

    assign w_vr  = i_s_axis_tuser[0] & i_s_axis_tuser[1];
    assign w_vd  = i_s_axis_tuser[0] & i_s_axis_tuser[2];
    assign w_vl  = i_s_axis_tuser[0] & i_s_axis_tuser[3];
    assign w_vu  = i_s_axis_tuser[0] & i_s_axis_tuser[4];
    assign w_top = i_s_axis_tuser[5];
    assign w_bot = i_s_axis_tuser[6];
    assign w_lef = i_s_axis_tuser[7];
    assign w_rig = i_s_axis_tuser[8];
    assign w_tl  = w_top | w_lef;
    assign w_br  = w_bot | w_rig;

    always_comb begin
        w_mode   = MODE_HOLD;
        w_vx     = '0;
        w_vy     = '0;
        w_vz_two = 1'b0;
        w_ok     = 1'b0;
        if ((w_top && w_bot) || (w_lef && w_rig)) begin
            w_mode = MODE_HOLD;
        end else if (!w_tl && !w_br) begin
            w_vz_two = 1'b1;
            w_mode   = MODE_CALC;
            if (w_vr && w_vd && w_vl && w_vu) begin
                w_vx = w_el - w_er;
                w_vy = w_ed - w_eu;
            end else if (w_vr && w_vd && w_vl) begin
                w_vx = w_el - w_er;
                w_vy = w_ed + w_ed;
            end else if (w_vr && w_vd && w_vu) begin
                w_vx = -(w_er + w_er);
                w_vy = w_ed - w_eu;
            end else if (w_vr && w_vl && w_vu) begin
                w_vx = w_el - w_er;
                w_vy = -(w_eu + w_eu);
            end else if (w_vd && w_vl && w_vu) begin
                w_vx = w_el + w_el;
                w_vy = w_ed - w_eu;
            end else if (w_vr && w_vd) begin
                w_vx = -(w_er + w_er);
                w_vy = w_ed + w_ed;
            end else if (w_vl && w_vu) begin
                w_vx = w_el + w_el;
                w_vy = -(w_eu + w_eu);
            end else begin
                w_mode = MODE_HOLD;
            end
        end else begin
            if (w_tl && !w_br) begin
                w_ok = w_vr && w_vd;
                w_vx = -w_er;
                w_vy = w_ed;
            end else if (w_br && !w_tl) begin
                w_ok = w_vl && w_vu;
                w_vx = w_el;
                w_vy = -w_eu;
            end else if (w_top && w_rig) begin
                w_ok = w_vd && w_vl;
                w_vx = w_el;
                w_vy = w_ed;
            end else begin
                w_ok = w_vr && w_vu;
                w_vx = -w_er;
                w_vy = -w_eu;
            end
            w_mode = w_ok ? MODE_CALC : MODE_UNDEF;
        end
    end

    assign w_neg_x = w_vx[VEC_W-1];
    assign w_neg_y = w_vy[VEC_W-1];
    assign w_abs_x = w_neg_x ? VEC_W'(-w_vx) : VEC_W'(w_vx);
    assign w_abs_y = w_neg_y ? VEC_W'(-w_vy) : VEC_W'(w_vy);

    assign w_ext_x = XY_W'(w_qx);
    assign w_ext_y = XY_W'(w_qy);

    assign o_s_axis_tready = (r_state == ST_IDLE);

    always_comb begin
        n_state      = r_state;
        n_mag_x      = r_mag_x;
        n_mag_y      = r_mag_y;
        n_mag_z      = r_mag_z;
        n_neg_x      = r_neg_x;
        n_neg_y      = r_neg_y;
        n_res        = r_res;
        n_out        = r_out;
        n_out_valid  = r_out_valid;
        n_last_x     = r_last_x;
        n_last_y     = r_last_y;
        n_last_z     = r_last_z;
        n_last_undef = r_last_undef;
        w_sq_start   = 1'b0;
        w_root_start = 1'b0;
        w_div_start  = 1'b0;

        if (r_out_valid && i_m_axis_tready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                if (i_s_axis_tvalid) begin
                    n_mag_x = MAG_W'(w_abs_x);
                    n_mag_y = MAG_W'(w_abs_y);
                    n_mag_z = MAG_W'(w_vz_two ? 2'd2 : 2'd1);
                    n_neg_x = w_neg_x;
                    n_neg_y = w_neg_y;
                    case (w_mode)
                        MODE_CALC: begin
                            n_state = ST_NORM;
                        end
                        MODE_UNDEF: begin
                            n_res   = '{undef: 1'b1, held: 1'b0, z: '0, y: '0, x: '0};
                            n_state = ST_OUT;
                        end
                        default: begin
                            n_res   = '{undef: r_last_undef, held: 1'b1, z: r_last_z,
                                        y: r_last_y, x: r_last_x};
                            n_state = ST_OUT;
                        end
                    endcase
                end
            end
            ST_NORM: begin
                if (r_mag_x[MAG_W-1] || r_mag_y[MAG_W-1] || r_mag_z[MAG_W-1]) begin
                    w_sq_start = 1'b1;
                    n_state    = ST_SQR;
                end else begin
                    n_mag_x = {r_mag_x[MAG_W-2:0], 1'b0};
                    n_mag_y = {r_mag_y[MAG_W-2:0], 1'b0};
                    n_mag_z = {r_mag_z[MAG_W-2:0], 1'b0};
                end
            end
            ST_SQR: begin
                if (w_sq_done) begin
                    w_root_start = 1'b1;
                    n_state      = ST_ROOT;
                end
            end
            ST_ROOT: begin
                if (w_root_done) begin
                    w_div_start = 1'b1;
                    n_state     = ST_DIV;
                end
            end
            ST_DIV: begin
                if (w_div_done) begin
                    n_res.x     = r_neg_x ? XY_W'(-w_ext_x) : w_ext_x;
                    n_res.y     = r_neg_y ? XY_W'(-w_ext_y) : w_ext_y;
                    n_res.z     = Z_W'(w_qz);
                    n_res.held  = 1'b0;
                    n_res.undef = 1'b0;
                    n_state     = ST_OUT;
                end
            end
            ST_OUT: begin
                if (!r_out_valid || i_m_axis_tready) begin
                    n_out       = r_res;
                    n_out_valid = 1'b1;
                    if (!r_res.held) begin
                        n_last_x     = r_res.x;
                        n_last_y     = r_res.y;
                        n_last_z     = r_res.z;
                        n_last_undef = r_res.undef;
                    end
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_out_valid  <= 1'b0;
            r_last_x     <= '0;
            r_last_y     <= '0;
            r_last_z     <= '0;
            r_last_undef <= 1'b1;
        end else begin
            r_state      <= n_state;
            r_out_valid  <= n_out_valid;
            r_last_x     <= n_last_x;
            r_last_y     <= n_last_y;
            r_last_z     <= n_last_z;
            r_last_undef <= n_last_undef;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mag_x <= n_mag_x;
        r_mag_y <= n_mag_y;
        r_mag_z <= n_mag_z;
        r_neg_x <= n_neg_x;
        r_neg_y <= n_neg_y;
        r_res   <= n_res;
        r_out   <= n_out;
    end

    hsn_sqsum u_sqsum (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_sq_start),
        .i_mag_x (r_mag_x),
        .i_mag_y (r_mag_y),
        .i_mag_z (r_mag_z),
        .o_done  (w_sq_done),
        .o_sum   (w_sum)
    );

    hsn_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_root_start),
        .i_sum   (w_sum),
        .o_done  (w_root_done),
        .o_root  (w_root)
    );

    hsn_div u_div_x (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_mag   (r_mag_x),
        .i_root  (w_root),
        .o_done  (w_div_done),
        .o_quo   (w_qx)
    );

    hsn_div u_div_y (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_mag   (r_mag_y),
        .i_root  (w_root),
        .o_done  (w_div_done_y),
        .o_quo   (w_qy)
    );

    hsn_div u_div_z (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_mag   (r_mag_z),
        .i_root  (w_root),
        .o_done  (w_div_done_z),
        .o_quo   (w_qz)
    );

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {1'b0, r_out.z, r_out.y, r_out.x};
    assign o_m_axis_tuser  = {r_out.undef, r_out.held};

`ifndef SYNTHESIS
    a_z_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (o_m_axis_tdata[2*XY_W +: Z_W] <= Z_W'(ONE_Q)))
        else $error("normal z above one");

    a_undef_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser[1]) |-> (o_m_axis_tdata == '0))
        else $error("undefined normal with nonzero components");

    a_div_lanes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_div_done || w_div_done_y || w_div_done_z) |->
            (w_div_done && w_div_done_y && w_div_done_z && r_state == ST_DIV))
        else $error("divider lanes out of step");
`endif

endmodule

>>> sv/hsn_sqsum.sv
// Bit-serial sum of squares of three magnitudes, most significant bit first.
module hsn_sqsum import hsn_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [MAG_W-1:0] i_mag_x,
    input  logic [MAG_W-1:0] i_mag_y,
    input  logic [MAG_W-1:0] i_mag_z,
    output logic             o_done,
    output logic [SUM_W-1:0] o_sum
);

    logic [MAG_W-1:0]    r_mx, r_my, r_mz;
    logic [MAG_W-1:0]    r_bx, r_by, r_bz;
    logic [SUM_W-1:0]    r_acc;
    logic [SQ_CNT_W-1:0] r_cnt;
    logic                r_busy;
    logic                r_done;
    logic [MAG_W+1:0]    w_pp;

    always_comb begin
        w_pp = (r_bx[MAG_W-1] ? (MAG_W+2)'(r_mx) : '0)
             + (r_by[MAG_W-1] ? (MAG_W+2)'(r_my) : '0)
             + (r_bz[MAG_W-1] ? (MAG_W+2)'(r_mz) : '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == SQ_CNT_W'(MAG_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_mx  <= i_mag_x;
            r_my  <= i_mag_y;
            r_mz  <= i_mag_z;
            r_bx  <= i_mag_x;
            r_by  <= i_mag_y;
            r_bz  <= i_mag_z;
            r_acc <= '0;
        end else if (r_busy) begin
            r_acc <= {r_acc[SUM_W-2:0], 1'b0} + SUM_W'(w_pp);
            r_bx  <= {r_bx[MAG_W-2:0], 1'b0};
            r_by  <= {r_by[MAG_W-2:0], 1'b0};
            r_bz  <= {r_bz[MAG_W-2:0], 1'b0};
        end
    end

    assign o_done = r_done;
    assign o_sum  = r_acc;

endmodule

>>> sv/hsn_sqrt.sv
// Digit-by-digit integer square root of the scaled sum, two radicand bits per cycle.
module hsn_sqrt import hsn_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [SUM_W-1:0]  i_sum,
    output logic              o_done,
    output logic [ROOT_W-1:0] o_root
);

    logic [RAD_W-1:0]      r_rad;
    logic [REM_W-1:0]      r_rem;
    logic [ROOT_W-1:0]     r_root;
    logic [ROOT_CNT_W-1:0] r_cnt;
    logic                  r_busy;
    logic                  r_done;
    logic [REM_W+1:0]      w_rem_sh;
    logic [REM_W+1:0]      w_trial;
    logic                  w_take;

    assign w_rem_sh = {r_rem, r_rad[RAD_W-1 -: 2]};
    assign w_trial  = (REM_W+2)'({r_root, 2'b01});
    assign w_take   = (w_rem_sh >= w_trial);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == ROOT_CNT_W'(ROOT_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rad  <= {i_sum, SCALE_SH'(0)};
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            r_rad <= {r_rad[RAD_W-3:0], 2'b00};
            if (w_take) begin
                r_rem  <= REM_W'(w_rem_sh - w_trial);
                r_root <= {r_root[ROOT_W-2:0], 1'b1};
            end else begin
                r_rem  <= REM_W'(w_rem_sh);
                r_root <= {r_root[ROOT_W-2:0], 1'b0};
            end
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;

endmodule

>>> sv/hsn_div.sv
// Restoring divider lane, one quotient bit per cycle, rounded by half the divisor.
module hsn_div import hsn_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [MAG_W-1:0]  i_mag,
    input  logic [ROOT_W-1:0] i_root,
    output logic              o_done,
    output logic [QUO_W-1:0]  o_quo
);

    logic [DIVD_W-1:0]    w_dvd;
    logic [ROOT_W-1:0]    r_rem;
    logic [QUO_W-1:0]     r_lo;
    logic [ROOT_W-1:0]    r_div;
    logic [QUO_W-1:0]     r_quo;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic                 r_busy;
    logic                 r_done;
    logic [ROOT_W:0]      w_sh;
    logic                 w_take;

    assign w_dvd  = {1'b0, i_mag, NUM_SH'(0)} + DIVD_W'(i_root >> 1);
    assign w_sh   = {r_rem, r_lo[QUO_W-1]};
    assign w_take = (w_sh >= {1'b0, r_div});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == DIV_CNT_W'(QUO_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= ROOT_W'(w_dvd[DIVD_W-1:QUO_W]);
            r_lo  <= w_dvd[QUO_W-1:0];
            r_div <= i_root;
            r_quo <= '0;
        end else if (r_busy) begin
            r_lo <= {r_lo[QUO_W-2:0], 1'b0};
            if (w_take) begin
                r_rem <= ROOT_W'(w_sh - {1'b0, r_div});
                r_quo <= {r_quo[QUO_W-2:0], 1'b1};
            end else begin
                r_rem <= ROOT_W'(w_sh);
                r_quo <= {r_quo[QUO_W-2:0], 1'b0};
            end
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;

endmodule

>>> dv/tb_top.sv
// Self-checking testbench for the heightmap surface normal unit: directed and random items.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import hsn_pkg::*;

    localparam int IDLE_LIMIT      = 3000;
    localparam int HOLD_OFF_CYCLES = 600;
    localparam int RANDOM_ITEMS    = 1000;
    localparam int DRAIN_CYCLES    = 100;

    localparam logic [3:0] NB_R   = 4'h1;
    localparam logic [3:0] NB_D   = 4'h2;
    localparam logic [3:0] NB_L   = 4'h4;
    localparam logic [3:0] NB_U   = 4'h8;
    localparam logic [3:0] NB_ALL = 4'hF;
    localparam logic [3:0] NB_NONE = 4'h0;

    localparam logic [3:0] EDGE_NONE  = 4'h0;
    localparam logic [3:0] EDGE_TOP   = 4'h1;
    localparam logic [3:0] EDGE_BOT   = 4'h2;
    localparam logic [3:0] EDGE_LEFT  = 4'h4;
    localparam logic [3:0] EDGE_RIGHT = 4'h8;

    class normal_scoreboard;
        t_normal     expected_q[$];
        int          errors;
        logic [15:0] last_x;
        logic [15:0] last_y;
        logic [15:0] last_z;
        logic        last_undef;

        function new();
            errors     = 0;
            last_x     = '0;
            last_y     = '0;
            last_z     = '0;
            last_undef = 1'b1;
        endfunction

        function longint unsigned int_sqrt(longint unsigned a);
            longint unsigned root;
            longint unsigned probe;
            root  = 0;
            probe = 64'h4000_0000_0000_0000;
            while (probe > a) probe = probe >> 2;
            while (probe != 0) begin
                if (a >= root + probe) begin
                    a    = a - (root + probe);
                    root = (root >> 1) + probe;
                end else begin
                    root = root >> 1;
                end
                probe = probe >> 2;
            end
            return root;
        endfunction

        function void unit_vector(input longint vx, input longint vy, input longint vz,
                                  output longint nx, output longint ny, output longint nz);
            longint          comp[3];
            longint          res[3];
            longint unsigned mag[3];
            longint unsigned mx;
            longint unsigned sum_sq;
            longint unsigned len;
            longint unsigned q;
            bit              neg[3];
            comp[0] = vx;
            comp[1] = vy;
            comp[2] = vz;
            mx = 0;
            for (int i = 0; i < 3; i++) begin
                neg[i] = comp[i] < 0;
                mag[i] = neg[i] ? longint'(-comp[i]) : comp[i];
                if (mag[i] > mx) mx = mag[i];
            end
            while (mx >= (64'd1 << 20)) begin
                for (int i = 0; i < 3; i++) mag[i] = mag[i] >> 1;
                mx = mx >> 1;
            end
            while (mx != 0 && mx < (64'd1 << 19)) begin
                for (int i = 0; i < 3; i++) mag[i] = mag[i] << 1;
                mx = mx << 1;
            end
            sum_sq = 0;
            for (int i = 0; i < 3; i++) sum_sq = sum_sq + mag[i] * mag[i];
            len = int_sqrt(sum_sq << 20);
            for (int i = 0; i < 3; i++) begin
                q = 0;
                if (len != 0) q = ((mag[i] << (FRAC_BITS + 10)) + (len >> 1)) / len;
                if (q > ONE_Q) q = ONE_Q;
                res[i] = neg[i] ? -longint'(q) : longint'(q);
            end
            nx = res[0];
            ny = res[1];
            nz = res[2];
        endfunction

        function t_normal predict(logic [IN_DATA_W-1:0] d, logic [IN_USER_W-1:0] u);
            longint  c, dr, dd, dl, du, vx, vy, vz, nx, ny, nz;
            logic    cv, vr, vd, vl, vu, top, bot, lef, rig, tl, br, ok;
            t_mode   mode;
            t_normal r;
            c  = longint'($signed(d[15:0]));
            dr = c - longint'($signed(d[31:16]));
            dd = c - longint'($signed(d[47:32]));
            dl = c - longint'($signed(d[63:48]));
            du = c - longint'($signed(d[79:64]));
            cv  = u[0];
            vr  = cv & u[1];
            vd  = cv & u[2];
            vl  = cv & u[3];
            vu  = cv & u[4];
            top = u[5];
            bot = u[6];
            lef = u[7];
            rig = u[8];
            tl  = top | lef;
            br  = bot | rig;
            vx  = 0;
            vy  = 0;
            vz  = 2;
            ok  = 1'b1;
            r   = '0;
            if ((top && bot) || (lef && rig)) begin
                mode = MODE_HOLD;
            end else if (!tl && !br) begin
                mode = MODE_CALC;
                if (vr && vd && vl && vu) begin
                    vx = dl - dr;  vy = dd - du;
                end else if (vr && vd && vl) begin
                    vx = dl - dr;  vy = 2 * dd;
                end else if (vr && vd && vu) begin
                    vx = -2 * dr;  vy = dd - du;
                end else if (vr && vl && vu) begin
                    vx = dl - dr;  vy = -2 * du;
                end else if (vd && vl && vu) begin
                    vx = 2 * dl;   vy = dd - du;
                end else if (vr && vd) begin
                    vx = -2 * dr;  vy = 2 * dd;
                end else if (vl && vu) begin
                    vx = 2 * dl;   vy = -2 * du;
                end else begin
                    mode = MODE_HOLD;
                end
            end else begin
                vz = 1;
                if (tl && !br) begin
                    ok = vr && vd;  vx = -dr;  vy = dd;
                end else if (br && !tl) begin
                    ok = vl && vu;  vx = dl;   vy = -du;
                end else if (top && rig) begin
                    ok = vd && vl;  vx = dl;   vy = dd;
                end else begin
                    ok = vr && vu;  vx = -dr;  vy = -du;
                end
                mode = ok ? MODE_CALC : MODE_UNDEF;
            end
            case (mode)
                MODE_HOLD: begin
                    r.x     = last_x;
                    r.y     = last_y;
                    r.z     = last_z[Z_W-1:0];
                    r.held  = 1'b1;
                    r.undef = last_undef;
                end
                MODE_UNDEF: begin
                    last_x     = '0;
                    last_y     = '0;
                    last_z     = '0;
                    last_undef = 1'b1;
                    r.undef    = 1'b1;
                end
                default: begin
                    unit_vector(vx, vy, vz, nx, ny, nz);
                    last_x     = nx[15:0];
                    last_y     = ny[15:0];
                    last_z     = nz[15:0];
                    last_undef = 1'b0;
                    r.x        = last_x;
                    r.y        = last_y;
                    r.z        = last_z[Z_W-1:0];
                end
            endcase
            return r;
        endfunction

        function void note_item(logic [IN_DATA_W-1:0] d, logic [IN_USER_W-1:0] u);
            expected_q.push_back(predict(d, u));
        endfunction

        function void check_result(t_normal got);
            t_normal want;
            if (expected_q.size() == 0) begin
                $error("unexpected result: x=%0d y=%0d z=%0d held=%0b undef=%0b",
                       $signed(got.x), $signed(got.y), got.z, got.held, got.undef);
                errors++;
                return;
            end
            want = expected_q.pop_front();
            if (got.x !== want.x) begin
                $error("normal_x: expected %0d, got %0d", $signed(want.x), $signed(got.x));
                errors++;
            end
            if (got.y !== want.y) begin
                $error("normal_y: expected %0d, got %0d", $signed(want.y), $signed(got.y));
                errors++;
            end
            if (got.z !== want.z) begin
                $error("normal_z: expected %0d, got %0d", want.z, got.z);
                errors++;
            end
            if (got.held !== want.held) begin
                $error("held_previous: expected %0b, got %0b", want.held, got.held);
                errors++;
            end
            if (got.undef !== want.undef) begin
                $error("undefined_normal: expected %0b, got %0b", want.undef, got.undef);
                errors++;
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_s_axis_tvalid;
    logic                  o_s_axis_tready;
    logic [IN_DATA_W-1:0]  i_s_axis_tdata;
    logic [IN_USER_W-1:0]  i_s_axis_tuser;
    logic                  o_m_axis_tvalid;
    logic                  i_m_axis_tready;
    logic [OUT_DATA_W-1:0] o_m_axis_tdata;
    logic [OUT_USER_W-1:0] o_m_axis_tuser;

    normal_scoreboard sb = new();
    bit               tx_steady;
    bit               hold_off_req;
    int               idle_cycles;

    heightmap_surface_normal_unit u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 60) return 0;
        if (roll < 90) return $urandom_range(1, 3);
        if (roll < 98) return $urandom_range(4, 15);
        return $urandom_range(30, 120);
    endfunction

    function automatic logic [15:0] pick_height(logic [15:0] base, int spread);
        int off;
        if (spread == 0) return 16'($urandom);
        off = $urandom_range(0, 2 * spread) - spread;
        return base + off[15:0];
    endfunction

    task automatic send_item(logic [15:0] hc, logic [15:0] hr, logic [15:0] hd,
                             logic [15:0] hl, logic [15:0] hu, logic cv,
                             logic [3:0] nb, logic [3:0] edges);
        int gap;
        gap = tx_steady ? 0 : pick_gap();
        if (gap > 0) begin
            i_s_axis_tvalid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_s_axis_tvalid = 1'b1;
        i_s_axis_tdata  = {hu, hl, hd, hr, hc};
        i_s_axis_tuser  = {edges, nb, cv};
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic send_random();
        logic [15:0] base;
        logic [3:0]  nb;
        logic [3:0]  edges;
        logic        cv;
        int          spread;
        int          kind;
        base = 16'($urandom);
        case ($urandom_range(0, 4))
            0: spread = 1;
            1: spread = 8;
            2: spread = 200;
            3: spread = 3000;
            default: spread = 0;
        endcase
        kind = $urandom_range(0, 99);
        if (kind < 55) begin
            edges = EDGE_NONE;
            cv    = ($urandom_range(0, 19) != 0);
            case ($urandom_range(0, 9))
                0, 1, 2: nb = NB_ALL;
                3: nb = NB_ALL & ~NB_R;
                4: nb = NB_ALL & ~NB_D;
                5: nb = NB_ALL & ~NB_L;
                6: nb = NB_ALL & ~NB_U;
                7: nb = NB_R | NB_D;
                8: nb = NB_L | NB_U;
                default: nb = 4'($urandom);
            endcase
        end else if (kind < 85) begin
            cv = 1'b1;
            nb = ($urandom_range(0, 3) == 0) ? 4'($urandom) : NB_ALL;
            case ($urandom_range(0, 7))
                0: edges = EDGE_TOP;
                1: edges = EDGE_LEFT;
                2: edges = EDGE_TOP | EDGE_LEFT;
                3: edges = EDGE_BOT;
                4: edges = EDGE_RIGHT;
                5: edges = EDGE_BOT | EDGE_RIGHT;
                6: edges = EDGE_TOP | EDGE_RIGHT;
                default: edges = EDGE_BOT | EDGE_LEFT;
            endcase
        end else begin
            cv    = 1'($urandom);
            nb    = 4'($urandom);
            edges = 4'($urandom);
        end
        send_item(pick_height(base, spread), pick_height(base, spread),
                  pick_height(base, spread), pick_height(base, spread),
                  pick_height(base, spread), cv, nb, edges);
    endtask

    initial begin
        int stall_left;
        int cycle;
        stall_left      = 0;
        cycle           = 0;
        i_m_axis_tready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            cycle++;
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                stall_left   = HOLD_OFF_CYCLES;
            end
            if (stall_left > 0) begin
                i_m_axis_tready = 1'b0;
                stall_left--;
            end else begin
                i_m_axis_tready = 1'b1;
                if ((cycle / 3000) % 3 != 2 && $urandom_range(0, 99) < 30) begin
                    stall_left = pick_gap();
                end
            end
        end
    end

    always @(posedge i_clk) begin
        t_normal got;
        if (i_rst_n) begin
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                got.x     = o_m_axis_tdata[15:0];
                got.y     = o_m_axis_tdata[31:16];
                got.z     = o_m_axis_tdata[46:32];
                got.held  = o_m_axis_tuser[0];
                got.undef = o_m_axis_tuser[1];
                sb.check_result(got);
            end
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                sb.note_item(i_s_axis_tdata, i_s_axis_tuser);
            end
            if ((o_m_axis_tvalid && i_m_axis_tready) || (i_s_axis_tvalid && o_s_axis_tready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles = idle_cycles + 1;
                if (idle_cycles >= IDLE_LIMIT) begin
                    $display("simulation failed");
                    $finish;
                end
            end
        end
    end

    initial begin
        idle_cycles     = 0;
        hold_off_req    = 1'b0;
        tx_steady       = 1'b0;
        i_rst_n         = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata  = '0;
        i_s_axis_tuser  = '0;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        send_item(16'd100, 16'd90, 16'd130, 16'd120, 16'd70, 1'b1, NB_NONE, EDGE_NONE);
        send_item(16'd100, 16'd90, 16'd130, 16'd120, 16'd70, 1'b1, NB_ALL, EDGE_NONE);
        send_item(16'd500, 16'd480, 16'd510, 16'd530, 16'd495, 1'b1, NB_ALL & ~NB_R, EDGE_NONE);
        send_item(16'd500, 16'd480, 16'd510, 16'd530, 16'd495, 1'b1, NB_ALL & ~NB_D, EDGE_NONE);
        send_item(16'd500, 16'd480, 16'd510, 16'd530, 16'd495, 1'b1, NB_ALL & ~NB_L, EDGE_NONE);
        send_item(16'd500, 16'd480, 16'd510, 16'd530, 16'd495, 1'b1, NB_ALL & ~NB_U, EDGE_NONE);
        send_item(16'hfff0, 16'h0010, 16'hff00, 16'h0003, 16'h0100, 1'b1, NB_R | NB_D, EDGE_NONE);
        send_item(16'hfff0, 16'h0010, 16'hff00, 16'h0003, 16'h0100, 1'b1, NB_L | NB_U, EDGE_NONE);
        send_item(16'd7, 16'd9, 16'd1, 16'd3, 16'd2, 1'b1, NB_R | NB_L, EDGE_NONE);
        send_item(16'd7, 16'd9, 16'd1, 16'd3, 16'd2, 1'b0, NB_ALL, EDGE_NONE);
        send_item(16'd40, 16'd10, 16'd90, 16'd30, 16'd20, 1'b1, NB_ALL, EDGE_TOP);
        send_item(16'd40, 16'd10, 16'd90, 16'd30, 16'd20, 1'b1, NB_ALL, EDGE_LEFT);
        send_item(16'd40, 16'd10, 16'd90, 16'd30, 16'd20, 1'b1, NB_ALL, EDGE_BOT);
        send_item(16'd40, 16'd10, 16'd90, 16'd30, 16'd20, 1'b1, NB_ALL, EDGE_RIGHT);
        send_item(16'd40, 16'd10, 16'd90, 16'd30, 16'd20, 1'b1, NB_ALL, EDGE_TOP | EDGE_RIGHT);
        send_item(16'd40, 16'd10, 16'd90, 16'd30, 16'd20, 1'b1, NB_ALL, EDGE_BOT | EDGE_LEFT);
        send_item(16'd40, 16'd10, 16'd90, 16'd30, 16'd20, 1'b1, NB_ALL, EDGE_TOP | EDGE_LEFT);
        send_item(16'd40, 16'd10, 16'd90, 16'd30, 16'd20, 1'b1, NB_ALL, EDGE_BOT | EDGE_RIGHT);
        send_item(16'd40, 16'd10, 16'd90, 16'd30, 16'd20, 1'b1, NB_ALL & ~NB_R, EDGE_TOP);
        send_item(16'd40, 16'd10, 16'd90, 16'd30, 16'd20, 1'b1, NB_NONE, EDGE_NONE);
        send_item(16'd40, 16'd10, 16'd90, 16'd30, 16'd20, 1'b1, NB_ALL, EDGE_TOP | EDGE_BOT);
        send_item(16'd40, 16'd10, 16'd90, 16'd30, 16'd20, 1'b1, NB_ALL, EDGE_LEFT | EDGE_RIGHT);
        send_item(16'h7fff, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 1'b1, NB_ALL, EDGE_NONE);
        send_item(16'h8000, 16'h7fff, 16'h7fff, 16'h8000, 16'h7fff, 1'b1, NB_ALL, EDGE_NONE);
        send_item(16'h7fff, 16'h8000, 16'h7fff, 16'h7fff, 16'h7fff, 1'b1, NB_ALL, EDGE_TOP);
        send_item(16'h1234, 16'h1234, 16'h1234, 16'h1234, 16'h1234, 1'b1, NB_ALL, EDGE_NONE);
        send_item(16'h1234, 16'h0034, 16'h1200, 16'h0004, 16'h1230, 1'b1, NB_ALL, 4'hF);

        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            tx_steady = ((i / 150) % 3 == 1);
            if (i == 300) hold_off_req = 1'b1;
            send_random();
        end
        i_s_axis_tvalid = 1'b0;

        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
